/* design/cdf_pkg.sv */
// Shared types and constants for the smartcard character deframer.
// Used by cdf_divider, cdf_framer and smartcard_char_deframer_core.
package cdf_pkg;

  localparam int unsigned FRAME_BITS  = 11;
  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned PRE_WIDTH   = 12;
  localparam int unsigned IDX_WIDTH   = 4;
  localparam int unsigned IO_BIT      = 6;

  localparam logic [PRE_WIDTH-1:0] PRESCALE_RESET = 12'd372;
  localparam logic [3:0]           ACTIVE_NIBBLE  = 4'hF;

  // result status codes
  localparam logic [1:0] ST_NONE  = 2'd0;
  localparam logic [1:0] ST_WAIT  = 2'd1;
  localparam logic [1:0] ST_BYTE  = 2'd2;
  localparam logic [1:0] ST_ERROR = 2'd3;

  typedef struct packed {
    logic                 start;
    logic [IDX_WIDTH-1:0] bit_times;
    logic                 active;
    logic                 io_level;
  } frm_ctrl_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [7:0]           data_byte;
    logic [IDX_WIDTH-1:0] bit_position;
  } frm_result_t;

endpackage

/* design/cdf_divider.sv */
// Bit-serial restoring divider: clock count / prescale, one quotient bit per cycle.
// Gives the rounded bit-time count saturated at FRAME_BITS + 1. Depends on cdf_pkg.
module cdf_divider (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [cdf_pkg::COUNT_WIDTH-1:0]  dividend_i,
  input  logic [cdf_pkg::PRE_WIDTH-1:0]    divisor_i,
  output logic                             done_o,
  output logic [cdf_pkg::IDX_WIDTH-1:0]    bit_times_o
);
  import cdf_pkg::*;

  localparam int unsigned CNT_W = $clog2(COUNT_WIDTH + 1);
  localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(COUNT_WIDTH);
  localparam logic [COUNT_WIDTH-1:0] SAT = COUNT_WIDTH'(FRAME_BITS + 1);

  logic [COUNT_WIDTH-1:0] dvd_q;   // dividend shifts out at top, quotient in at bottom
  logic [PRE_WIDTH-1:0]   rem_q;
  logic [PRE_WIDTH-1:0]   dsr_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   busy_q;
  logic                   done_q;

  logic [PRE_WIDTH:0]     trial;
  logic                   qbit;
  logic [PRE_WIDTH-1:0]   rem_d;
  logic                   round_up;
  logic [IDX_WIDTH-1:0]   q_small;

  assign trial = {rem_q, dvd_q[COUNT_WIDTH-1]};
  assign qbit  = (trial >= {1'b0, dsr_q});
  assign rem_d = qbit ? PRE_WIDTH'(trial - {1'b0, dsr_q}) : trial[PRE_WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_LOAD;
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      // zero prescale behaves as one
      dsr_q <= (divisor_i == '0) ? PRE_WIDTH'(1) : divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[COUNT_WIDTH-2:0], qbit};
      rem_q <= rem_d;
    end
  end

  // round up when remainder exceeds half the divisor
  assign round_up = (rem_q > (dsr_q >> 1));
  assign q_small  = dvd_q[IDX_WIDTH-1:0] + IDX_WIDTH'(round_up);

  assign done_o      = done_q;
  assign bit_times_o = (dvd_q >= SAT) ? IDX_WIDTH'(FRAME_BITS + 1) : q_small;

endmodule

/* design/cdf_framer.sv */
// Frame shift register and bit-time sequencer: one bit time per cycle.
// Holds frame bits, bit index and last I/O level. Depends on cdf_pkg.
module cdf_framer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cdf_pkg::frm_ctrl_t    ctrl_i,
  output logic                  done_o,
  output cdf_pkg::frm_result_t  result_o
);
  import cdf_pkg::*;

  localparam logic [IDX_WIDTH-1:0] IDX_FULL = IDX_WIDTH'(FRAME_BITS);

  logic [FRAME_BITS-1:0] frame_q;   // first stored bit ends up at bit 0
  logic [IDX_WIDTH-1:0]  idx_q;
  logic [IDX_WIDTH-1:0]  cnt_q;
  logic                  last_io_q;
  logic                  busy_q;
  logic                  done_q;
  logic                  active_q;
  logic                  io_q;
  logic [1:0]            status_q;
  logic [7:0]            data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q   <= '0;
      idx_q     <= '0;
      cnt_q     <= '0;
      last_io_q <= 1'b0;
      busy_q    <= 1'b0;
      done_q    <= 1'b0;
      status_q  <= ST_NONE;
      data_q    <= '0;
    end else if (ctrl_i.start) begin
      cnt_q    <= ctrl_i.bit_times;
      busy_q   <= 1'b1;
      done_q   <= 1'b0;
      status_q <= ST_NONE;
      data_q   <= '0;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        last_io_q <= io_q;
        busy_q    <= 1'b0;
        done_q    <= 1'b1;
      end else if (idx_q == '0 && !active_q) begin
        // idle line in start state: rest of the gap is dropped
        status_q <= ST_WAIT;
        cnt_q    <= '0;
      end else if (idx_q != IDX_FULL) begin
        frame_q  <= {last_io_q, frame_q[FRAME_BITS-1:1]};
        idx_q    <= idx_q + IDX_WIDTH'(1);
        status_q <= ST_WAIT;
        cnt_q    <= cnt_q - IDX_WIDTH'(1);
      end else begin
        // start bit low, guard bit high
        if (!frame_q[0] && frame_q[FRAME_BITS-1]) begin
          status_q <= ST_BYTE;
          data_q   <= frame_q[8:1];
        end else begin
          status_q <= ST_ERROR;
          data_q   <= '0;
        end
        frame_q <= '0;
        idx_q   <= '0;
        cnt_q   <= '0;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      active_q <= ctrl_i.active;
      io_q     <= ctrl_i.io_level;
    end
  end

  assign done_o                = done_q;
  assign result_o.status       = status_q;
  assign result_o.data_byte    = data_q;
  assign result_o.bit_position = idx_q;

endmodule

/* design/smartcard_char_deframer_core.sv */
// Smartcard character deframer: top level with stream channels and prescale register.
// Instantiates cdf_divider and cdf_framer; depends on cdf_pkg.
//
// Usage: each input beat is one line-change event (pin byte + clock count since the
// previous event). Each beat produces exactly one output beat carrying a status, the
// decoded character when a frame completes, and the frame bit count afterwards.
// Processing: the count is divided by the prescale in a bit-serial divider, then the
// frame sequencer steps through each bit time of the gap (at most 12) and finishes,
// then the output register loads.
// Throughput: one event at a time; s_axis_tready rises again once the result has moved
// into the output register, so a new beat can be taken while the result awaits pickup.
// Stall: if m_axis_tready stays low, the result waits in the output register and the
// next finished result holds inside the core until the register frees up.
// Reset: prescale returns to 372, the frame is empty, last I/O level is zero, and
// both channels are idle. cfg_we_i writes prescale; write only while no event is in work.
module smartcard_char_deframer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,     // prescale
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,    // [7:0] pin_state, [39:8] clock_count
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata     // [1:0] status, [9:2] data_byte, [13:10] bit_position
);
  import cdf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FRAME,
    S_HOLD
  } state_e;

  state_e               state_q;
  logic [PRE_WIDTH-1:0] prescale_q;
  logic [7:0]           pin_q;
  logic                 out_valid_q;
  frm_result_t          out_q;

  logic                 in_fire;
  logic                 out_free;
  logic                 out_load;
  logic                 div_done;
  logic [IDX_WIDTH-1:0] bit_times;
  frm_ctrl_t            frm_ctrl;
  logic                 frm_done;
  frm_result_t          frm_result;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign out_load = (state_q == S_HOLD || (state_q == S_FRAME && frm_done)) && out_free;

  cdf_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_fire),
    .dividend_i  (s_axis_tdata[39:8]),
    .divisor_i   (prescale_q),
    .done_o      (div_done),
    .bit_times_o (bit_times)
  );

  assign frm_ctrl.start     = div_done;
  assign frm_ctrl.bit_times = bit_times;
  assign frm_ctrl.active    = (pin_q[7:4] == ACTIVE_NIBBLE);
  assign frm_ctrl.io_level  = pin_q[IO_BIT];

  cdf_framer u_frm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (frm_ctrl),
    .done_o   (frm_done),
    .result_o (frm_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prescale_q  <= PRESCALE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        prescale_q <= cfg_wdata_i;
      end
      out_valid_q <= out_load || (out_valid_q && !m_axis_tready);
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_FRAME;
          end
        end
        S_FRAME, S_HOLD: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end else if (frm_done) begin
            state_q <= S_HOLD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pin_q <= s_axis_tdata[7:0];
    end
    if (out_load) begin
      out_q <= frm_result;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.bit_position, out_q.data_byte, out_q.status};

endmodule

/* verif/smartcard_char_deframer_core_test.sv */
// Self-checking testbench for smartcard_char_deframer_core.
// Builds character frames from line-change events and checks each result beat
// against an in-bench deframer model. Depends on cdf_pkg and the core RTL.
`timescale 1ns / 100ps

module smartcard_char_deframer_core_test;
  import cdf_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned CFG_PERIOD   = 70;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [11:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;

  // deframer model state
  logic [PRE_WIDTH-1:0]  prescale_q;
  logic [FRAME_BITS-1:0] frame_q;
  logic [IDX_WIDTH-1:0]  frame_idx;
  logic                  last_io;

  frm_result_t pending_chars[$];
  int unsigned error_count;
  int unsigned items_sent;
  int unsigned cycle_count;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;

  smartcard_char_deframer_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("smartcard_char_deframer_core regression: fail");
      $finish;
    end
  end

  // Bit times of one event, then the frame sequencer over those bit times.
  function automatic frm_result_t predict_char(input logic [7:0] pin, input logic [31:0] count);
    logic [31:0] div;
    logic [31:0] ticks;
    frm_result_t res;
    logic        done;
    int unsigned k;
    div   = (prescale_q == 0) ? 32'd1 : 32'(prescale_q);
    ticks = count / div;
    if ((count % div) > (div >> 1)) ticks = ticks + 1;
    if (ticks > FRAME_BITS + 1) ticks = FRAME_BITS + 1;
    res.status    = ST_NONE;
    res.data_byte = '0;
    done          = 1'b0;
    for (k = 0; k < ticks && !done; k++) begin
      if (frame_idx == 0 && pin[7:4] != ACTIVE_NIBBLE) begin
        res.status = ST_WAIT;
        done       = 1'b1;
      end else if (frame_idx < FRAME_BITS) begin
        frame_q[frame_idx] = last_io;
        frame_idx          = frame_idx + IDX_WIDTH'(1);
        res.status         = ST_WAIT;
      end else begin
        // start bit low, guard bit high; parity is ignored
        if (!frame_q[0] && frame_q[FRAME_BITS-1]) begin
          res.status    = ST_BYTE;
          res.data_byte = frame_q[8:1];
        end else begin
          res.status = ST_ERROR;
        end
        frame_q   = '0;
        frame_idx = '0;
        done      = 1'b1;
      end
    end
    last_io          = pin[IO_BIT];
    res.bit_position = frame_idx;
    return res;
  endfunction

  // Clock count that rounds to n bit times, jittered across the rounding window.
  function automatic logic [31:0] ticks_to_count(input int unsigned n);
    int unsigned p;
    p = (prescale_q == 0) ? 1 : prescale_q;
    if (p >= 3 && n > 0 && $urandom_range(1))
      return n * p - $urandom_range(1, p - p / 2 - 1);
    return n * p + $urandom_range(0, p / 2);
  endfunction

  // Leaves tvalid high after the handshake so back-to-back beats need no extra step.
  task automatic send_event(input logic [7:0] pin, input logic [31:0] count);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {count, pin};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_chars.push_back(predict_char(pin, count));
    items_sent++;
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_prescale(input logic [PRE_WIDTH-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    prescale_q = value;
  endtask

  // fb[0] start bit, fb[8:1] data LSB first, fb[9] parity, fb[10] guard.
  // Each event stores the previous event's level once per bit time.
  task automatic send_frame(input logic [FRAME_BITS-1:0] fb);
    int unsigned pos;
    int unsigned n;
    int unsigned extra;
    logic [7:0]  pin;
    pin    = 8'($urandom);
    pin[6] = fb[0];
    send_event(pin, ticks_to_count(0));
    pos   = 0;
    extra = 0;
    while (pos < FRAME_BITS) begin
      n = 1;
      while (pos + n < FRAME_BITS && fb[pos+n] == fb[pos]) n++;
      // splitting the first run would drop the frame, so only later runs split
      if (pos > 0 && n > 1 && $urandom_range(3) == 0) n = $urandom_range(1, n - 1);
      pin = 8'($urandom);
      if (pos + n < FRAME_BITS) pin[6] = fb[pos+n];
      if (pos == 0 && pin[6]) pin[7:4] = ACTIVE_NIBBLE;
      extra = (pos + n == FRAME_BITS && $urandom_range(1)) ? 1 : 0;
      send_event(pin, ticks_to_count(n + extra));
      pos += n;
    end
    if (extra == 0) begin
      if ($urandom_range(7) == 0) send_event(8'($urandom), $urandom | 32'h8000_0000);
      else send_event(8'($urandom), ticks_to_count($urandom_range(1, FRAME_BITS + 1)));
    end
  endtask

  task automatic send_noise;
    logic [31:0] count;
    case ($urandom_range(4))
      0: count = ticks_to_count($urandom_range(0, FRAME_BITS + 2));
      1: count = $urandom;
      2: count = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      default: count = $urandom_range(0, 3 * prescale_q);
    endcase
    send_event(8'($urandom), count);
  endtask

  function automatic logic [FRAME_BITS-1:0] random_frame();
    logic [FRAME_BITS-1:0] fb;
    fb     = FRAME_BITS'($urandom);
    fb[0]  = ($urandom_range(9) == 0);
    fb[10] = ($urandom_range(9) != 0);
    return fb;
  endfunction

  task automatic test_directed;
    send_event(8'h00, 32'h0);                 // no bit time
    send_event(8'h3F, 32'hFFFF_FFFF);         // inactive pin in start state
    send_event(8'hF0, 32'(PRESCALE_RESET / 2)); // exactly half rounds down
    send_event(8'hFF, 32'(PRESCALE_RESET / 2 + 1)); // just above half rounds up
    send_event(8'h00, 32'hFFFF_FFFF);         // long gap runs to the check
    send_frame({1'b1, 1'b0, 8'h00, 1'b0});    // byte 0x00
    send_frame({1'b1, 1'b1, 8'hFF, 1'b0});    // byte 0xFF
    send_frame({1'b1, 1'b0, 8'hA5, 1'b1});    // start bit high: dropped or error
    send_frame({1'b0, 1'b1, 8'h5A, 1'b0});    // guard bit low: frame error
  endtask

  task automatic test_prescale_extremes;
    logic [PRE_WIDTH-1:0] pick[4];
    int unsigned i;
    pick = '{12'd1, 12'd4095, 12'd2, 12'd3};
    for (i = 0; i < 4; i++) begin
      write_prescale(pick[i]);
      send_frame({1'b1, 1'b0, 8'($urandom), 1'b0});
      send_noise();
      send_frame(random_frame());
      send_noise();
    end
  endtask

  task automatic test_random_traffic(input int unsigned src_pct, input int unsigned snk_pct);
    int unsigned goal;
    int unsigned next_cfg;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    goal     = items_sent + RANDOM_ITEMS;
    next_cfg = items_sent;
    while (items_sent < goal) begin
      if (items_sent >= next_cfg) begin
        case ($urandom_range(5))
          0: write_prescale(12'd1);
          1: write_prescale(12'd4095);
          2: write_prescale(PRESCALE_RESET);
          3: write_prescale(12'($urandom_range(2, 7)));
          default: write_prescale(12'($urandom_range(1, 4095)));
        endcase
        next_cfg = items_sent + CFG_PERIOD;
      end
      if ($urandom_range(3) == 0) send_noise();
      else send_frame(random_frame());
    end
  endtask

  // result checker and random backpressure
  always @(posedge clk_i) begin
    frm_result_t exp_char;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, m_axis_tdata);
        error_count++;
      end else begin
        exp_char = pending_chars.pop_front();
        if (m_axis_tdata[1:0] != exp_char.status) begin
          $display("%0t: status exp %0d got %0d", $time, exp_char.status, m_axis_tdata[1:0]);
          error_count++;
        end
        if (m_axis_tdata[9:2] != exp_char.data_byte) begin
          $display("%0t: data_byte exp %h got %h", $time, exp_char.data_byte,
                   m_axis_tdata[9:2]);
          error_count++;
        end
        if (m_axis_tdata[13:10] != exp_char.bit_position) begin
          $display("%0t: bit_position exp %0d got %0d", $time, exp_char.bit_position,
                   m_axis_tdata[13:10]);
          error_count++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    error_count   = 0;
    items_sent    = 0;
    cycle_count   = 0;
    src_idle_pct  = 31;
    snk_idle_pct  = 51;
    prescale_q    = PRESCALE_RESET;
    frame_q       = '0;
    frame_idx     = '0;
    last_io       = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_prescale_extremes();
    test_random_traffic(31, 51);
    test_random_traffic(51, 31);
    test_random_traffic(0, 0);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("smartcard_char_deframer_core regression: pass");
    end else begin
      $display("smartcard_char_deframer_core regression: fail");
    end
    $finish;
  end

endmodule
